### rtl/binomial_mod_prime_unit_macros.svh
// Assertion macros for the binomial mod prime unit.
// Expects clk and rst_n (synchronous, active low) in the scope of use.
`ifndef BINOMIAL_MOD_PRIME_UNIT_MACROS_SVH
`define BINOMIAL_MOD_PRIME_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define BMP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("binomial_mod_prime_unit: implication check failed");

// Next-cycle implication
`define BMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("binomial_mod_prime_unit: next-cycle check failed");

`endif

### rtl/bmp_pkg.sv
// Shared types and constants for the binomial mod prime unit.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package bmp_pkg;

  localparam int FIELD_W       = 16;
  localparam int CFG_W         = 31;
  localparam int RES_W         = 31;
  localparam int MAX_N_DEF     = 65535;
  localparam int MOD_WIDTH_DEF = 31;
  localparam logic [CFG_W-1:0] CFG_RESET = 31'd1000000007;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FACT,
    ST_FACT_WAIT,
    ST_INV_LOOP,
    ST_ACC_WAIT,
    ST_SQ_START,
    ST_SQ_WAIT,
    ST_RES_WAIT,
    ST_INV2_INIT,
    ST_EMIT
  } ctrl_state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_FACT_STEP,
    DP_FACT_SAVE,
    DP_INV_R_INIT,
    DP_INV_NR_INIT,
    DP_MUL_ACC,
    DP_SAVE_ACC,
    DP_MUL_SQ,
    DP_SAVE_SQ,
    DP_MUL_FN,
    DP_MUL_RES,
    DP_SAVE_RES,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_req;  // request answers zero without arithmetic
    logic i_eq_n;    // running product has reached n!
    logic e_zero;    // exponent fully consumed
    logic e_lsb;     // current exponent bit
    logic mul_done;  // modular product ready this cycle
    logic out_free;  // output register can take an item
  } dp_status_t;

endpackage

### rtl/bmp_modmul.sv
// Bit-serial interleaved modular multiplier: a*b mod p, one bit of b per cycle.
// Depends on nothing outside itself; operands must already be below p.
`timescale 1ns / 1ps

module bmp_modmul #(
  parameter int MOD_WIDTH = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [MOD_WIDTH-1:0] op_a,
  input  logic [MOD_WIDTH-1:0] op_b,
  input  logic [MOD_WIDTH-1:0] modulus,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] product
);

  localparam int CNT_W = $clog2(MOD_WIDTH + 1);

  logic [MOD_WIDTH-1:0] acc_r;
  logic [MOD_WIDTH-1:0] a_r;
  logic [MOD_WIDTH-1:0] b_r;
  logic [MOD_WIDTH-1:0] p_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [MOD_WIDTH:0]   dbl;
  logic [MOD_WIDTH:0]   dbl_red;
  logic [MOD_WIDTH:0]   sum;
  logic [MOD_WIDTH:0]   sum_red;
  logic [MOD_WIDTH-1:0] acc_nxt;

  // Double, reduce, add the selected multiplicand, reduce
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, p_r}) ? (dbl - {1'b0, p_r}) : dbl;
    sum     = dbl_red + (b_r[MOD_WIDTH-1] ? {1'b0, a_r} : '0);
    sum_red = (sum >= {1'b0, p_r}) ? (sum - {1'b0, p_r}) : sum;
    acc_nxt = sum_red[MOD_WIDTH-1:0];
  end

  // Control: count down one step per bit, pulse done after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(MOD_WIDTH);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Operand and accumulator registers
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= op_a;
      b_r   <= op_b;
      p_r   <= modulus;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[MOD_WIDTH-2:0], 1'b0};
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

### rtl/bmp_datapath.sv
// Datapath: request registers, factorial run, Fermat inversion and output stage.
// Depends on bmp_pkg and bmp_modmul; driven by bmp_ctrl commands.
`timescale 1ns / 1ps

module bmp_datapath #(
  parameter int MAX_N     = bmp_pkg::MAX_N_DEF,
  parameter int MOD_WIDTH = bmp_pkg::MOD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bmp_pkg::dp_cmd_t            cmd,
  output bmp_pkg::dp_status_t         status,
  input  logic [bmp_pkg::FIELD_W-1:0] top_count,
  input  logic [bmp_pkg::FIELD_W-1:0] choose_count,
  input  logic                        cfg_we,
  input  logic [bmp_pkg::CFG_W-1:0]   cfg_value,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [bmp_pkg::RES_W-1:0]   binomial_residue,
  output logic                        bad_request
);

  logic [bmp_pkg::CFG_W-1:0]   cfg_r;
  logic [bmp_pkg::FIELD_W-1:0] n_r;
  logic [bmp_pkg::FIELD_W-1:0] r_r;
  logic [bmp_pkg::FIELD_W-1:0] nr_r;
  logic [bmp_pkg::FIELD_W-1:0] i_r;
  logic [MOD_WIDTH-1:0]        p_r;
  logic [MOD_WIDTH-1:0]        imod_r;
  logic [MOD_WIDTH-1:0]        run_r;
  logic [MOD_WIDTH-1:0]        fn_r;
  logic [MOD_WIDTH-1:0]        fr_r;
  logic [MOD_WIDTH-1:0]        fnr_r;
  logic [MOD_WIDTH-1:0]        e_r;
  logic [MOD_WIDTH-1:0]        acc_r;
  logic [MOD_WIDTH-1:0]        sq_r;
  logic [MOD_WIDTH-1:0]        res_r;
  logic                        zero_r;
  logic                        bad_r;
  logic                        out_valid_r;
  logic [bmp_pkg::RES_W-1:0]   out_res_r;
  logic                        out_bad_r;

  logic [MOD_WIDTH-1:0] p_in;
  logic                 bad_in;
  logic                 small_in;
  logic [MOD_WIDTH:0]   imod_inc;
  logic [MOD_WIDTH-1:0] imod_nxt;
  logic                 mul_start;
  logic [MOD_WIDTH-1:0] mul_a;
  logic [MOD_WIDTH-1:0] mul_b;
  logic                 mul_done;
  logic [MOD_WIDTH-1:0] mul_prod;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= bmp_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_value;
    end
  end

  // Request screening and i mod p increment
  always_comb begin
    p_in     = MOD_WIDTH'(cfg_r);
    bad_in   = (choose_count > top_count) || (32'(top_count) > 32'(MAX_N));
    small_in = (p_in < MOD_WIDTH'(2));
    imod_inc = {1'b0, imod_r} + (MOD_WIDTH+1)'(1);
    imod_nxt = (imod_inc == {1'b0, p_r}) ? '0 : imod_inc[MOD_WIDTH-1:0];
  end

  // Select multiplier operands for the issuing operation
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (cmd.op)
      bmp_pkg::DP_FACT_STEP: begin
        mul_start = 1'b1;
        mul_a     = run_r;
        mul_b     = imod_nxt;
      end
      bmp_pkg::DP_MUL_ACC: begin
        mul_start = 1'b1;
        mul_a     = acc_r;
        mul_b     = sq_r;
      end
      bmp_pkg::DP_MUL_SQ: begin
        mul_start = 1'b1;
        mul_a     = sq_r;
        mul_b     = sq_r;
      end
      bmp_pkg::DP_MUL_FN: begin
        mul_start = 1'b1;
        mul_a     = fn_r;
        mul_b     = acc_r;
      end
      bmp_pkg::DP_MUL_RES: begin
        mul_start = 1'b1;
        mul_a     = res_r;
        mul_b     = acc_r;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  bmp_modmul #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .modulus(p_r),
    .done   (mul_done),
    .product(mul_prod)
  );

  // Working registers, updated per command
  always_ff @(posedge clk) begin
    case (cmd.op)
      bmp_pkg::DP_LOAD: begin
        n_r    <= top_count;
        r_r    <= choose_count;
        nr_r   <= top_count - choose_count;
        p_r    <= p_in;
        zero_r <= bad_in || small_in;
        bad_r  <= bad_in;
        i_r    <= '0;
        imod_r <= '0;
        run_r  <= MOD_WIDTH'(1);
        fn_r   <= MOD_WIDTH'(1);
        fr_r   <= MOD_WIDTH'(1);
        fnr_r  <= MOD_WIDTH'(1);
      end
      bmp_pkg::DP_FACT_STEP: begin
        i_r    <= i_r + bmp_pkg::FIELD_W'(1);
        imod_r <= imod_nxt;
      end
      bmp_pkg::DP_FACT_SAVE: begin
        run_r <= mul_prod;
        if (i_r == n_r) fn_r <= mul_prod;
        if (i_r == r_r) fr_r <= mul_prod;
        if (i_r == nr_r) fnr_r <= mul_prod;
      end
      bmp_pkg::DP_INV_R_INIT: begin
        acc_r <= MOD_WIDTH'(1);
        sq_r  <= fr_r;
        e_r   <= p_r - MOD_WIDTH'(2);
      end
      bmp_pkg::DP_INV_NR_INIT: begin
        acc_r <= MOD_WIDTH'(1);
        sq_r  <= fnr_r;
        e_r   <= p_r - MOD_WIDTH'(2);
      end
      bmp_pkg::DP_SAVE_ACC: begin
        acc_r <= mul_prod;
      end
      bmp_pkg::DP_SAVE_SQ: begin
        sq_r <= mul_prod;
        e_r  <= e_r >> 1;
      end
      bmp_pkg::DP_SAVE_RES: begin
        res_r <= mul_prod;
      end
      default: begin
        n_r <= n_r;
      end
    endcase
  end

  // Output stage: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == bmp_pkg::DP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == bmp_pkg::DP_EMIT) begin
      out_res_r <= zero_r ? '0 : bmp_pkg::RES_W'(res_r);
      out_bad_r <= bad_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign binomial_residue = out_res_r;
  assign bad_request      = out_bad_r;

  // Status back to the controller
  always_comb begin
    status.zero_req = zero_r;
    status.i_eq_n   = (i_r == n_r);
    status.e_zero   = (e_r == '0);
    status.e_lsb    = e_r[0];
    status.mul_done = mul_done;
    status.out_free = !out_valid_r || out_ready;
  end

endmodule

### rtl/bmp_ctrl.sv
// Controller state machine: sequences factorial run, inversions and output.
// Depends on bmp_pkg; talks to bmp_datapath through command and status structs.
`timescale 1ns / 1ps

module bmp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmp_pkg::dp_status_t status,
  output bmp_pkg::dp_cmd_t    cmd
);

  bmp_pkg::ctrl_state_t state_r;
  bmp_pkg::ctrl_state_t state_nxt;
  logic                 pass_r;
  logic                 pass_nxt;

  // State and pass registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmp_pkg::ST_IDLE;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    cmd.op    = bmp_pkg::DP_NOP;
    in_ready  = 1'b0;
    case (state_r)
      bmp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = bmp_pkg::DP_LOAD;
          state_nxt = bmp_pkg::ST_CHECK;
        end
      end
      bmp_pkg::ST_CHECK: begin
        state_nxt = status.zero_req ? bmp_pkg::ST_EMIT : bmp_pkg::ST_FACT;
      end
      bmp_pkg::ST_FACT: begin
        if (status.i_eq_n) begin
          cmd.op    = bmp_pkg::DP_INV_R_INIT;
          pass_nxt  = 1'b0;
          state_nxt = bmp_pkg::ST_INV_LOOP;
        end else begin
          cmd.op    = bmp_pkg::DP_FACT_STEP;
          state_nxt = bmp_pkg::ST_FACT_WAIT;
        end
      end
      bmp_pkg::ST_FACT_WAIT: begin
        if (status.mul_done) begin
          cmd.op    = bmp_pkg::DP_FACT_SAVE;
          state_nxt = bmp_pkg::ST_FACT;
        end
      end
      // One exponent bit: optional multiply into acc, then square; at exponent zero, fold acc into the result
      bmp_pkg::ST_INV_LOOP: begin
        if (status.e_zero) begin
          cmd.op    = pass_r ? bmp_pkg::DP_MUL_RES : bmp_pkg::DP_MUL_FN;
          state_nxt = bmp_pkg::ST_RES_WAIT;
        end else if (status.e_lsb) begin
          cmd.op    = bmp_pkg::DP_MUL_ACC;
          state_nxt = bmp_pkg::ST_ACC_WAIT;
        end else begin
          cmd.op    = bmp_pkg::DP_MUL_SQ;
          state_nxt = bmp_pkg::ST_SQ_WAIT;
        end
      end
      bmp_pkg::ST_ACC_WAIT: begin
        if (status.mul_done) begin
          cmd.op    = bmp_pkg::DP_SAVE_ACC;
          state_nxt = bmp_pkg::ST_SQ_START;
        end
      end
      bmp_pkg::ST_SQ_START: begin
        cmd.op    = bmp_pkg::DP_MUL_SQ;
        state_nxt = bmp_pkg::ST_SQ_WAIT;
      end
      bmp_pkg::ST_SQ_WAIT: begin
        if (status.mul_done) begin
          cmd.op    = bmp_pkg::DP_SAVE_SQ;
          state_nxt = bmp_pkg::ST_INV_LOOP;
        end
      end
      bmp_pkg::ST_RES_WAIT: begin
        if (status.mul_done) begin
          cmd.op    = bmp_pkg::DP_SAVE_RES;
          state_nxt = pass_r ? bmp_pkg::ST_EMIT : bmp_pkg::ST_INV2_INIT;
        end
      end
      bmp_pkg::ST_INV2_INIT: begin
        cmd.op    = bmp_pkg::DP_INV_NR_INIT;
        pass_nxt  = 1'b1;
        state_nxt = bmp_pkg::ST_INV_LOOP;
      end
      bmp_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.op    = bmp_pkg::DP_EMIT;
          state_nxt = bmp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bmp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/binomial_mod_prime_unit.sv
// C(n,r) mod p. One item at a time; every modular product runs on the single
// bit-serial multiplier, which sets the whole rate. Reset (rst_n low, synchronous)
// idles the block, empties the output and sets p to 1000000007. Depends on bmp_pkg,
// bmp_ctrl, bmp_datapath and the macro header.
`timescale 1ns / 1ps
`include "binomial_mod_prime_unit_macros.svh"

module binomial_mod_prime_unit #(
  parameter int MAX_N     = bmp_pkg::MAX_N_DEF,
  parameter int MOD_WIDTH = bmp_pkg::MOD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] top_count, [31:16] choose_count
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [30:0] binomial_residue, [31] zero fill
  output logic [0:0]  out_tuser,  // [0] bad_request
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data    // prime_modulus
);

  bmp_pkg::dp_cmd_t          dp_cmd;
  bmp_pkg::dp_status_t       dp_status;
  logic [bmp_pkg::RES_W-1:0] residue;
  logic                      bad;

  assign cfg_ready = 1'b1;

  bmp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .status  (dp_status),
    .cmd     (dp_cmd)
  );

  bmp_datapath #(
    .MAX_N    (MAX_N),
    .MOD_WIDTH(MOD_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .status          (dp_status),
    .top_count       (in_tdata[15:0]),
    .choose_count    (in_tdata[31:16]),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_value       (cfg_data),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .binomial_residue(residue),
    .bad_request     (bad)
  );

  // Pack the result item
  assign out_tdata = {1'b0, residue};
  assign out_tuser = bad;

  // Checks
  `BMP_ASSERT_NEXT(a_one_item_in_flight, in_tvalid && in_tready, !in_tready)
  `BMP_ASSERT_IMP(a_bad_gives_zero, out_tvalid && out_tuser[0], out_tdata == 32'd0)
  `BMP_ASSERT_IMP(a_emit_needs_room, dp_cmd.op == bmp_pkg::DP_EMIT, dp_status.out_free)

endmodule

### tb/tb_binomial_mod_prime_unit.sv
// Self-checking testbench for binomial_mod_prime_unit: C(n,r) mod p over a stream port.
// Depends on bmp_pkg and the unit; predicts each answer and checks results in order.
`timescale 1ns / 1ps

module tb_binomial_mod_prime_unit;

  import bmp_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int IDLE_PCT    = 29;
  localparam int MAX_N_TB    = MAX_N_DEF;

  typedef struct {
    logic [FIELD_W-1:0] top_count;
    logic [FIELD_W-1:0] choose_count;
    logic [RES_W-1:0]   residue;
    logic               bad_request;
  } binomial_answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_data = '0;

  // Predictor state: the modulus the block holds
  logic [CFG_W-1:0] modulus_shadow = CFG_RESET;

  binomial_answer_t pending_answers[$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  steady = 1'b0;

  binomial_mod_prime_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [15:0] top_count, [31:16] choose_count
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [30:0] binomial_residue, [31] zero fill
    .out_tuser (out_tuser),   // [0] bad_request
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)     // prime_modulus
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Inverse of base by raising it to p-2, square and multiply
  function automatic longint unsigned fermat_power(input longint unsigned base,
                                                   input longint unsigned p);
    longint unsigned e, acc, sq;
    e   = p - 2;
    acc = 1 % p;
    sq  = base % p;
    while (e > 0) begin
      if (e[0]) acc = (acc * sq) % p;
      sq = (sq * sq) % p;
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic binomial_answer_t predict_binomial(input logic [FIELD_W-1:0] n,
                                                        input logic [FIELD_W-1:0] r,
                                                        input logic [CFG_W-1:0] modulus);
    binomial_answer_t ans;
    longint unsigned p, run, fact_n, fact_r, fact_nr, res;
    int unsigned nr;
    ans.top_count    = n;
    ans.choose_count = r;
    ans.residue      = '0;
    ans.bad_request  = 1'b0;
    // Out-of-range request: flag it, answer zero
    if (r > n || int'(n) > MAX_N_TB) begin
      ans.bad_request = 1'b1;
      return ans;
    end
    p = longint'(modulus) & ((64'd1 << MOD_WIDTH_DEF) - 1);
    // Modulus 0 or 1 answers zero
    if (p < 2) return ans;
    nr      = 32'(n - r);
    run     = 1 % p;
    fact_n  = run;
    fact_r  = run;
    fact_nr = run;
    for (int unsigned i = 1; i <= n; i++) begin
      run = (run * (i % p)) % p;
      if (i == n)  fact_n  = run;
      if (i == r)  fact_r  = run;
      if (i == nr) fact_nr = run;
    end
    res = (fact_n * fermat_power(fact_r, p)) % p;
    res = (res * fermat_power(fact_nr, p)) % p;
    ans.residue = res[RES_W-1:0];
    return ans;
  endfunction

  // Result side: random stalls, check each accepted item against the oldest answer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_answers.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: residue %0d bad %0b", out_tdata[30:0], out_tuser[0]);
          mismatch_count <= mismatch_count + 1;
        end else begin
          binomial_answer_t want;
          want = pending_answers.pop_front();
          if (out_tdata[30:0] !== want.residue || out_tuser[0] !== want.bad_request) begin
            if (mismatch_count < 10)
              $display("mismatch n=%0d r=%0d: expected residue %0d bad %0b, got residue %0d bad %0b",
                       want.top_count, want.choose_count, want.residue, want.bad_request,
                       out_tdata[30:0], out_tuser[0]);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      out_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one request, idling at random first; valid stays high after acceptance
  task automatic send_request(input logic [FIELD_W-1:0] n, input logic [FIELD_W-1:0] r);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, n};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_answers.push_back(predict_binomial(n, r, modulus_shadow));
  endtask

  // Drop valid and hold off until every answer has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the modulus register; call only when idle
  task automatic set_modulus(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    modulus_shadow = value;
    cfg_valid <= 1'b0;
  endtask

  // Field extremes, edge choices and bad requests under the reset modulus
  task automatic test_reset_modulus();
    send_request(16'd0, 16'd0);
    send_request(16'd1, 16'd0);
    send_request(16'd1, 16'd1);
    send_request(16'd5, 16'd2);
    send_request(16'd20, 16'd10);
    send_request(16'd64, 16'd63);
    send_request(16'd1000, 16'd500);
    send_request(16'd3, 16'd4);
    send_request(16'd0, 16'hFFFF);
    send_request(16'h8000, 16'hFFFF);
    send_request(16'h7FFF, 16'h8000);
    wait_idle();
  endtask

  // Tiny primes: exponent zero for p=2, n at or above p
  task automatic test_small_primes();
    set_modulus(31'd2);
    send_request(16'd5, 16'd2);
    send_request(16'd1, 16'd1);
    wait_idle();
    set_modulus(31'd3);
    send_request(16'd4, 16'd2);
    send_request(16'd2, 16'd1);
    wait_idle();
    set_modulus(31'd7);
    send_request(16'd10, 16'd3);
    send_request(16'd6, 16'd3);
    wait_idle();
  endtask

  // Modulus 1 and 0 force zero; bad requests still flagged
  task automatic test_degenerate_modulus();
    set_modulus(31'd1);
    send_request(16'd5, 16'd2);
    send_request(16'd3, 16'd4);
    wait_idle();
    set_modulus(31'd0);
    send_request(16'd0, 16'd0);
    send_request(16'd2, 16'd3);
    wait_idle();
  endtask

  // Largest modulus and a composite one
  task automatic test_wide_and_composite();
    set_modulus(31'h7FFFFFFF);
    send_request(16'd30, 16'd15);
    send_request(16'd12, 16'd12);
    wait_idle();
    set_modulus(31'd6);
    send_request(16'd5, 16'd2);
    send_request(16'd4, 16'd1);
    wait_idle();
  endtask

  // Random requests over several moduli; mostly valid with small n
  task automatic test_random_requests();
    logic [CFG_W-1:0] moduli[15];
    logic [CFG_W-1:0] pick;
    logic [FIELD_W-1:0] n, r;
    int sel;
    moduli = '{31'd2, 31'd3, 31'd5, 31'd7, 31'd11, 31'd13, 31'd65537, 31'd998244353,
               31'd1000000007, 31'h7FFFFFFF, 31'd1, 31'd0, 31'd4, 31'd9, 31'd0};
    for (int phase = 0; phase < 4; phase++) begin
      // First phase runs without any idling
      steady = (phase == 0);
      sel  = $urandom_range(14);
      pick = (sel == 14) ? CFG_W'($urandom()) : moduli[sel];
      set_modulus(pick);
      for (int k = 0; k < 20; k++) begin
        sel = $urandom_range(99);
        if (sel < 20) begin
          // Bad request anywhere in the field range
          n = FIELD_W'($urandom_range(65534));
          r = FIELD_W'($urandom_range(65535, int'(n) + 1));
        end else if (sel < 24) begin
          n = FIELD_W'($urandom_range(1500));
          r = FIELD_W'($urandom_range(int'(n)));
        end else begin
          n = FIELD_W'($urandom_range(63));
          r = FIELD_W'($urandom_range(int'(n)));
        end
        send_request(n, r);
        // Hold off mid-phase once until the unit is empty
        if (phase == 2 && k == 9) wait_idle();
      end
      wait_idle();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_modulus();
    test_small_primes();
    test_degenerate_modulus();
    test_wide_and_composite();
    test_random_requests();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### binomial_mod_prime_unit.f
+incdir+rtl
rtl/bmp_pkg.sv
rtl/bmp_modmul.sv
rtl/bmp_datapath.sv
rtl/bmp_ctrl.sv
rtl/binomial_mod_prime_unit.sv
tb/tb_binomial_mod_prime_unit.sv
